// ----- design/boxiou_pkg.sv -----
// Shared constants and types for the box intersection-over-union unit.
package boxiou_pkg;

    // Depth of the queue between the front stage and the arithmetic pipeline.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QIDX_BITS   = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Occupancy report from the queue to both of its neighbours.
    typedef struct packed {
        logic                 empty;
        logic                 full;
        logic [QCNT_BITS-1:0] count;
    } t_queue_status;

endpackage

// ----- design/box_intersection_over_union_unit.sv -----
// Top level of the box intersection-over-union unit.
//
//  Channel  Direction  Handshake           Payload
//  in       input      i_valid / o_stall   i_a_* and i_b_* box corners
//  out      output     o_valid / i_stall   o_iou, o_overlap_area, o_overlaps, o_empty_union
//
// Without stalls, one box pair is accepted per cycle and one result leaves per cycle.
// The divider resolves one quotient bit per pipeline stage after the area
// multipliers and the union stage.
// A four-beat queue sits between the front stage and the arithmetic pipeline.
// A stalled output beat freezes the arithmetic pipeline; the queue fills and
// then the input stalls. Reset is synchronous and clears the valid flags and
// the queue pointers and occupancy.
module box_intersection_over_union_unit #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [COORD_BITS-1:0]   i_a_left,
    input  logic [COORD_BITS-1:0]   i_a_top,
    input  logic [COORD_BITS-1:0]   i_a_right,
    input  logic [COORD_BITS-1:0]   i_a_bottom,
    input  logic [COORD_BITS-1:0]   i_b_left,
    input  logic [COORD_BITS-1:0]   i_b_top,
    input  logic [COORD_BITS-1:0]   i_b_right,
    input  logic [COORD_BITS-1:0]   i_b_bottom,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [FRAC_BITS:0]      o_iou,
    output logic [2*COORD_BITS-1:0] o_overlap_area,
    output logic                    o_overlaps,
    output logic                    o_empty_union
);

    localparam int unsigned DW = 6 * COORD_BITS;

    logic                      w_push, w_pop;
    logic [DW-1:0]             w_push_data, w_pop_data;
    boxiou_pkg::t_queue_status w_q_status;

    // Front stage: corner comparison and side lengths.
    boxiou_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_a_left    (i_a_left),
        .i_a_top     (i_a_top),
        .i_a_right   (i_a_right),
        .i_a_bottom  (i_a_bottom),
        .i_b_left    (i_b_left),
        .i_b_top     (i_b_top),
        .i_b_right   (i_b_right),
        .i_b_bottom  (i_b_bottom),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Decoupling queue.
    boxiou_queue #(
        .DATA_BITS (DW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_status    (w_q_status)
    );

    // Areas, union and ratio.
    boxiou_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (!w_q_status.empty),
        .i_q_data       (w_pop_data),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_iou          (o_iou),
        .o_overlap_area (o_overlap_area),
        .o_overlaps     (o_overlaps),
        .o_empty_union  (o_empty_union)
    );

endmodule

// ----- design/boxiou_front.sv -----
// Front stage: takes box pairs, forms side lengths and intersection sides.
module boxiou_front #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [COORD_BITS-1:0]         i_a_left,
    input  logic [COORD_BITS-1:0]         i_a_top,
    input  logic [COORD_BITS-1:0]         i_a_right,
    input  logic [COORD_BITS-1:0]         i_a_bottom,
    input  logic [COORD_BITS-1:0]         i_b_left,
    input  logic [COORD_BITS-1:0]         i_b_top,
    input  logic [COORD_BITS-1:0]         i_b_right,
    input  logic [COORD_BITS-1:0]         i_b_bottom,
    input  boxiou_pkg::t_queue_status     i_q_status,
    output logic                          o_push,
    output logic [6*COORD_BITS-1:0]       o_push_data
);

    localparam int unsigned C    = COORD_BITS;
    localparam int unsigned OCCW = boxiou_pkg::QCNT_BITS + 1;

    logic                r_f_valid;
    logic [6*C-1:0]      r_f_data;
    logic [C-1:0]        w_wa, w_ha, w_wb, w_hb, w_wi, w_hi;
    logic [C-1:0]        w_il, w_it, w_ir, w_ib;
    logic [OCCW-1:0]     w_occ;
    logic                w_accept;

    // Side length of a span, clamped to zero when inverted or empty.
    function automatic logic [C-1:0] span(input logic [C-1:0] lo, input logic [C-1:0] hi);
        span = (hi > lo) ? (hi - lo) : '0;
    endfunction

    // Intersection box: larger top-left and smaller bottom-right corner.
    always_comb begin
        w_il = (i_a_left   > i_b_left)   ? i_a_left   : i_b_left;
        w_it = (i_a_top    > i_b_top)    ? i_a_top    : i_b_top;
        w_ir = (i_a_right  < i_b_right)  ? i_a_right  : i_b_right;
        w_ib = (i_a_bottom < i_b_bottom) ? i_a_bottom : i_b_bottom;
        w_wa = span(i_a_left, i_a_right);
        w_ha = span(i_a_top, i_a_bottom);
        w_wb = span(i_b_left, i_b_right);
        w_hb = span(i_b_top, i_b_bottom);
        w_wi = span(w_il, w_ir);
        w_hi = span(w_it, w_ib);
    end

    // Stall while the queue could not take both the held beat and a new one.
    assign w_occ    = OCCW'(i_q_status.count) + OCCW'(r_f_valid);
    assign o_stall  = (w_occ >= OCCW'(boxiou_pkg::QUEUE_DEPTH));
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f_data <= {w_hi, w_wi, w_hb, w_wb, w_ha, w_wa};
        end
    end

    // The held beat always has room in the queue, so it is pushed at once.
    assign o_push      = r_f_valid;
    assign o_push_data = r_f_data;

endmodule

// ----- design/boxiou_queue.sv -----
// Short queue that decouples the front stage from the arithmetic pipeline.
module boxiou_queue #(
    parameter int unsigned DATA_BITS = 96
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [DATA_BITS-1:0]      i_push_data,
    input  logic                      i_pop,
    output logic [DATA_BITS-1:0]      o_pop_data,
    output boxiou_pkg::t_queue_status o_status
);

    localparam int unsigned IW = boxiou_pkg::QIDX_BITS;
    localparam int unsigned CW = boxiou_pkg::QCNT_BITS;

    logic [DATA_BITS-1:0] r_mem [boxiou_pkg::QUEUE_DEPTH];
    logic [IW-1:0]        r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]        r_count;

    // Pointers wrap at the queue depth.
    function automatic logic [IW-1:0] bump(input logic [IW-1:0] p);
        bump = (p == IW'(boxiou_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data     = r_mem[r_rd_ptr];
    assign o_status.count = r_count;
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CW'(boxiou_pkg::QUEUE_DEPTH));

    // A beat is never written into a full queue unless one is read in the same cycle.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_status.full || i_pop))
        else $error("queue written while full");

    // A beat is never read from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue read while empty");

    // A lone write raises the occupancy by exactly one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue occupancy did not follow a write");

endmodule

// ----- design/boxiou_back.sv -----
// Back pipeline: areas, union and the restoring divider for the ratio.
module boxiou_back #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  logic [6*COORD_BITS-1:0]   i_q_data,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [FRAC_BITS:0]        o_iou,
    output logic [2*COORD_BITS-1:0]   o_overlap_area,
    output logic                      o_overlaps,
    output logic                      o_empty_union
);

    localparam int unsigned C = COORD_BITS;
    localparam int unsigned A = 2 * COORD_BITS;
    localparam int unsigned U = A + 1;
    localparam int unsigned R = A + 2;
    localparam int unsigned F = FRAC_BITS;

    logic          w_en;
    logic [C-1:0]  w_wa, w_ha, w_wb, w_hb, w_wi, w_hi;

    logic          r_m_vld;
    logic [A-1:0]  r_m_aa, r_m_ab, r_m_ai;

    logic          r_u_vld, r_u_emp;
    logic [U-1:0]  r_u_den;
    logic [A-1:0]  r_u_inter;
    logic [U-1:0]  w_uni;

    logic          r_vld   [F+1];
    logic          r_emp   [F+1];
    logic [U-1:0]  r_rem   [F+1];
    logic [U-1:0]  r_den   [F+1];
    logic [F:0]    r_quo   [F+1];
    logic [A-1:0]  r_inter [F+1];

    logic          r_out_valid, r_out_emp;
    logic [F:0]    r_out_iou;
    logic [A-1:0]  r_out_area;

    // The whole pipeline moves unless the output beat is held.
    assign w_en  = !(r_out_valid && i_stall);
    assign o_pop = w_en && i_q_valid;

    assign {w_hi, w_wi, w_hb, w_wb, w_ha, w_wa} = i_q_data;

    // Stage one: the three areas.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_aa <= A'(w_wa) * A'(w_ha);
            r_m_ab <= A'(w_wb) * A'(w_hb);
            r_m_ai <= A'(w_wi) * A'(w_hi);
        end
    end

    // Stage two: union area; the intersection never exceeds either area.
    assign w_uni = U'(r_m_aa) + U'(r_m_ab) - U'(r_m_ai);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_vld <= 1'b0;
        end else if (w_en) begin
            r_u_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u_den   <= w_uni;
            r_u_inter <= r_m_ai;
            r_u_emp   <= (w_uni == '0);
        end
    end

    // Divider, integer bit: the numerator is at most the denominator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= r_u_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (U'(r_u_inter) >= r_u_den) begin
                r_rem[0] <= U'(r_u_inter) - r_u_den;
                r_quo[0] <= (F+1)'(1);
            end else begin
                r_rem[0] <= U'(r_u_inter);
                r_quo[0] <= '0;
            end
            r_den[0]   <= r_u_den;
            r_inter[0] <= r_u_inter;
            r_emp[0]   <= r_u_emp;
        end
    end

    // Divider, one fraction bit per stage.
    for (genvar k = 1; k <= F; k++) begin : g_step
        logic [R-1:0] w_rs, w_ds;
        logic         w_ge;

        assign w_rs = {r_rem[k-1], 1'b0};
        assign w_ds = R'(r_den[k-1]);
        assign w_ge = (w_rs >= w_ds);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[k]   <= w_ge ? U'(w_rs - w_ds) : U'(w_rs);
                r_quo[k]   <= {r_quo[k-1][F-1:0], w_ge};
                r_den[k]   <= r_den[k-1];
                r_inter[k] <= r_inter[k-1];
                r_emp[k]   <= r_emp[k-1];
            end
        end
    end

    // Output register; an empty union forces the ratio to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_vld[F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_iou  <= r_emp[F] ? '0 : r_quo[F];
            r_out_area <= r_inter[F];
            r_out_emp  <= r_emp[F];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_iou          = r_out_iou;
    assign o_overlap_area = r_out_area;
    assign o_overlaps     = (r_out_area != '0);
    assign o_empty_union  = r_out_emp;

    // An empty union carries no overlap and a zero ratio.
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty_union) |-> (o_iou == '0 && o_overlap_area == '0))
        else $error("empty union with non-zero result");

    // The ratio never exceeds one.
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_iou <= ((F+1)'(1) << F)))
        else $error("ratio above one");

    // Full overlap only when the areas coincide with a non-empty union.
    a_full_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_iou == ((F+1)'(1) << F)) |-> (o_overlaps && !o_empty_union))
        else $error("ratio of one without overlap");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the box intersection-over-union unit.
`timescale 1ns / 1ps

module tb;

    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 16;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int RANDOM_PAIRS = 750;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_AFTER   = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MODE_BEATS   = 48;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_box;

    typedef struct packed {
        t_box a;
        t_box b;
    } t_box_pair;

    typedef struct packed {
        logic [FRAC_BITS:0]      iou;
        logic [2*COORD_BITS-1:0] overlap_area;
        logic                    overlaps;
        logic                    empty_union;
    } t_iou_result;

    // Idle styles: none, short gaps only, or mostly short with the odd long one.
    typedef enum int {
        IDLE_NONE,
        IDLE_SHORT,
        IDLE_MIXED
    } t_idle_mode;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    t_coord                  i_a_left = '0;
    t_coord                  i_a_top = '0;
    t_coord                  i_a_right = '0;
    t_coord                  i_a_bottom = '0;
    t_coord                  i_b_left = '0;
    t_coord                  i_b_top = '0;
    t_coord                  i_b_right = '0;
    t_coord                  i_b_bottom = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [FRAC_BITS:0]      o_iou;
    logic [2*COORD_BITS-1:0] o_overlap_area;
    logic                    o_overlaps;
    logic                    o_empty_union;

    t_box_pair   pending_pairs[$];
    t_iou_result expected_results[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          hold_left = 0;

    box_intersection_over_union_unit #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_a_left       (i_a_left),
        .i_a_top        (i_a_top),
        .i_a_right      (i_a_right),
        .i_a_bottom     (i_a_bottom),
        .i_b_left       (i_b_left),
        .i_b_top        (i_b_top),
        .i_b_right      (i_b_right),
        .i_b_bottom     (i_b_bottom),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_iou          (o_iou),
        .o_overlap_area (o_overlap_area),
        .o_overlaps     (o_overlaps),
        .o_empty_union  (o_empty_union)
    );

    // Free-running clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Side length along one axis; a reversed or zero span gives zero.
    function automatic longint unsigned side_len(t_coord lo, t_coord hi);
        return (hi > lo) ? 64'(hi - lo) : 64'd0;
    endfunction

    // Intersection area, flags and the truncated Q1.16 ratio for one box pair.
    function automatic t_iou_result predict_iou(t_box_pair p);
        longint unsigned area_a, area_b, inter, uni;
        t_coord          il, it, ir, ib;
        t_iou_result     r;
        area_a = side_len(p.a.left, p.a.right) * side_len(p.a.top, p.a.bottom);
        area_b = side_len(p.b.left, p.b.right) * side_len(p.b.top, p.b.bottom);
        il     = (p.a.left > p.b.left) ? p.a.left : p.b.left;
        it     = (p.a.top > p.b.top) ? p.a.top : p.b.top;
        ir     = (p.a.right < p.b.right) ? p.a.right : p.b.right;
        ib     = (p.a.bottom < p.b.bottom) ? p.a.bottom : p.b.bottom;
        inter  = side_len(il, ir) * side_len(it, ib);
        uni    = area_a + area_b - inter;
        r.empty_union  = (uni == 0);
        r.iou          = (FRAC_BITS+1)'((uni == 0) ? 64'd0 : (inter << FRAC_BITS) / uni);
        r.overlap_area = (2*COORD_BITS)'(inter);
        r.overlaps     = (inter != 0);
        return r;
    endfunction

    // Saturate a coordinate into the legal range.
    function automatic t_coord sat_coord(int v);
        if (v < 0) return '0;
        if (v > COORD_MAX) return t_coord'(COORD_MAX);
        return t_coord'(v);
    endfunction

    function automatic t_box make_box(int l, int t, int w, int h);
        t_box b;
        b.left   = sat_coord(l);
        b.top    = sat_coord(t);
        b.right  = sat_coord(l + w);
        b.bottom = sat_coord(t + h);
        return b;
    endfunction

    function automatic t_box_pair make_pair(int al, int at, int ar, int ab,
                                            int bl, int bt, int br, int bb);
        t_box_pair p;
        p.a = '{t_coord'(al), t_coord'(at), t_coord'(ar), t_coord'(ab)};
        p.b = '{t_coord'(bl), t_coord'(bt), t_coord'(br), t_coord'(bb)};
        return p;
    endfunction

    // Random pair, mostly boxes close enough to overlap, with some noise.
    function automatic t_box_pair random_pair();
        t_box_pair p;
        int        kind, lim, l, t, w, h, dl, dt, hh, ww;
        kind = $urandom_range(0, 99);
        lim  = (1 << $urandom_range(1, COORD_BITS)) - 1;
        l    = $urandom_range(0, COORD_MAX);
        t    = $urandom_range(0, COORD_MAX);
        w    = $urandom_range(0, lim);
        h    = $urandom_range(0, lim);
        p.a  = make_box(l, t, w, h);
        if (kind < 45) begin
            p.b = make_box(l + int'($urandom_range(0, 2 * lim)) - lim,
                           t + int'($urandom_range(0, 2 * lim)) - lim,
                           $urandom_range(0, lim), $urandom_range(0, lim));
        end else if (kind < 55) begin
            // Identical boxes, or the second one nested inside the first.
            if ($urandom_range(0, 1)) begin
                p.b = p.a;
            end else begin
                dl  = $urandom_range(0, w);
                dt  = $urandom_range(0, h);
                p.b = make_box(l + dl, t + dt, $urandom_range(0, w - dl),
                               $urandom_range(0, h - dt));
            end
        end else if (kind < 65) begin
            // Neighbours sharing an edge or a corner.
            p.b = make_box(l + w * (int'($urandom_range(0, 2)) - 1),
                           t + h * (int'($urandom_range(0, 2)) - 1), w, h);
        end else if (kind < 80) begin
            p = {$urandom, $urandom, $urandom, $urandom};
        end else if (kind < 90) begin
            // Flat or reversed boxes.
            p.b = make_box(l + int'($urandom_range(0, lim)), t, w, h);
            case ($urandom_range(0, 3))
                0: begin
                    p.a.right = p.a.left;
                end
                1: begin
                    p.a.bottom = sat_coord(int'(p.a.top) - int'($urandom_range(0, lim)));
                end
                2: begin
                    p.a.right  = p.a.left;
                    p.b.bottom = p.b.top;
                end
                default: begin
                    p.a.right = sat_coord(int'(p.a.left) - int'($urandom_range(1, lim)));
                    p.b.right = sat_coord(int'(p.b.left) - int'($urandom_range(0, lim)));
                end
            endcase
        end else begin
            // A wide flat bar crossing a tall narrow one.
            hh  = $urandom_range(0, h / 4);
            ww  = $urandom_range(0, w / 4);
            p.a = make_box(l, t + h / 2 - hh, w, 2 * hh);
            p.b = make_box(l + w / 2 - ww, t, 2 * ww, h);
        end
        return p;
    endfunction

    function automatic int pick_idle(t_idle_mode mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_SHORT: return $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
            default:    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                           : $urandom_range(0, 2);
        endcase
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Compare one result beat with the oldest outstanding expectation.
    task automatic check_result(t_iou_result got);
        t_iou_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result beat with nothing outstanding, iou", got.iou, 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.iou !== want.iou)
            report_mismatch("iou", got.iou, want.iou);
        if (got.overlap_area !== want.overlap_area)
            report_mismatch("overlap_area", got.overlap_area, want.overlap_area);
        if (got.overlaps !== want.overlaps)
            report_mismatch("overlaps", got.overlaps, want.overlaps);
        if (got.empty_union !== want.empty_union)
            report_mismatch("empty_union", got.empty_union, want.empty_union);
    endtask

    // Input driver: presents queued pairs, holding each until it is taken.
    always @(posedge i_clk) begin : drive_proc
        t_box_pair         pair;
        int                gap_left = 0;
        int                beats_in_mode = 0;
        t_idle_mode        send_mode = IDLE_NONE;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                expected_results.push_back(predict_iou(pair));
            if (hold_left != 0)
                gap_left = 0;
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    pair = pending_pairs.pop_front();
                    i_a_left   <= pair.a.left;
                    i_a_top    <= pair.a.top;
                    i_a_right  <= pair.a.right;
                    i_a_bottom <= pair.a.bottom;
                    i_b_left   <= pair.b.left;
                    i_b_top    <= pair.b.top;
                    i_b_right  <= pair.b.right;
                    i_b_bottom <= pair.b.bottom;
                    i_valid    <= 1'b1;
                    if (beats_in_mode == 0) begin
                        send_mode     = t_idle_mode'($urandom_range(0, 2));
                        beats_in_mode = MODE_BEATS;
                    end
                    beats_in_mode--;
                    gap_left = pick_idle(send_mode);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each accepted beat and drives the stall.
    always @(posedge i_clk) begin : monitor_proc
        t_iou_result       got;
        int                results_seen = 0;
        int                stall_left = 0;
        int                cycles_in_mode = 0;
        bit                hold_done = 1'b0;
        t_idle_mode        recv_mode = IDLE_NONE;
        if (i_rst_n && o_valid && !i_stall) begin
            got.iou          = o_iou;
            got.overlap_area = o_overlap_area;
            got.overlaps     = o_overlaps;
            got.empty_union  = o_empty_union;
            check_result(got);
            results_seen++;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            // One long hold-off so the pipeline and its queue back up.
            hold_done = 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            if (cycles_in_mode == 0) begin
                recv_mode      = t_idle_mode'($urandom_range(0, 2));
                cycles_in_mode = MODE_BEATS;
            end
            cycles_in_mode--;
            stall_left = ($urandom_range(0, 3) == 0) ? pick_idle(recv_mode) : 0;
            i_stall <= 1'b0;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("box_intersection_over_union_unit: mismatch");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus_proc
        // Directed pairs: extremes, empty union, touching, nesting and crossing.
        pending_pairs.push_back(make_pair(0, 0, COORD_MAX, COORD_MAX,
                                          0, 0, COORD_MAX, COORD_MAX));
        pending_pairs.push_back(make_pair(10, 10, 20, 20, 10, 10, 20, 20));
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 20, 20, 30, 30));
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 10, 0, 20, 10));
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 10, 10, 20, 20));
        pending_pairs.push_back(make_pair(5, 5, 5, 5, 7, 7, 7, 9));
        pending_pairs.push_back(make_pair(10, 10, 5, 5, COORD_MAX, COORD_MAX, 0, 0));
        pending_pairs.push_back(make_pair(30, 30, 10, 10, 0, 0, 4, 4));
        pending_pairs.push_back(make_pair(0, 0, 100, 100, 25, 25, 75, 75));
        pending_pairs.push_back(make_pair(0, 40, 100, 60, 40, 0, 60, 100));
        pending_pairs.push_back(make_pair(40, 0, 60, 100, 0, 40, 100, 60));
        pending_pairs.push_back(make_pair(0, 0, 3, 3, 1, 1, 4, 4));
        pending_pairs.push_back(make_pair(5, 5, 5, 50, 0, 0, 10, 100));
        pending_pairs.push_back(make_pair(COORD_MAX - 1, COORD_MAX - 1, COORD_MAX, COORD_MAX,
                                          0, 0, COORD_MAX, COORD_MAX));
        pending_pairs.push_back(make_pair(0, 0, 1, 1, 0, 0, COORD_MAX, COORD_MAX));
        pending_pairs.push_back(make_pair('h5555, 'h5555, 'hAAAA, 'hAAAA,
                                          'hAAAA, 'hAAAA, 'hFFFF, 'hFFFF));
        pending_pairs.push_back(make_pair('h2AAA, 'h1555, 'hD555, 'hEAAA,
                                          'h0000, 'h4000, 'hFFFF, 'hBFFF));
        pending_pairs.push_back(make_pair(0, 0, 2, 1, 1, 0, 3, 1));
        pending_pairs.push_back(make_pair(0, 0, COORD_MAX, 1, 0, 0, 1, COORD_MAX));
        pending_pairs.push_back(make_pair(0, 0, COORD_MAX, COORD_MAX,
                                          0, 0, COORD_MAX, 32768));
        pending_pairs.push_back(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                          COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        repeat (RANDOM_PAIRS)
            pending_pairs.push_back(random_pair());

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every pair to be taken and every result to be seen.
        while (pending_pairs.size() != 0 || i_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("box_intersection_over_union_unit: match");
        end else begin
            $display("box_intersection_over_union_unit: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/boxiou_pkg.sv
design/boxiou_front.sv
design/boxiou_queue.sv
design/boxiou_back.sv
design/box_intersection_over_union_unit.sv
tb/sv/tb.sv
